FILE: hw/rtl/sst_pkg.sv
`timescale 1ns / 1ps

package sst_pkg;

  localparam int unsigned TickMs      = 10;
  localparam int unsigned PressSatMs  = 10000;
  localparam int unsigned ForceMs     = 5000;
  localparam int unsigned SetupMs     = 3000;
  localparam int unsigned NormalMs    = 50;
  localparam int unsigned WdtMs       = 15000;
  localparam int unsigned SchedMs     = 100;
  localparam int unsigned UptimeArmMs = 3000;
  localparam int unsigned UptimeSatMs = 3010;
  localparam int unsigned LoadHigh    = 75;
  localparam int unsigned LoadMed     = 30;

  localparam logic [7:0] FreqLow  = 8'd80;
  localparam logic [7:0] FreqMed  = 8'd160;
  localparam logic [7:0] FreqHigh = 8'd240;

  typedef enum logic [2:0] {
    REASON_NONE     = 3'd0,
    REASON_NORMAL   = 3'd1,
    REASON_SETUP    = 3'd2,
    REASON_FORCED   = 3'd3,
    REASON_WATCHDOG = 3'd4,
    REASON_THERMAL  = 3'd5
  } reason_e;

  typedef enum logic [1:0] {
    CFG_ENGINE_ENABLE  = 2'd0,
    CFG_EMERGENCY_TEMP = 2'd1,
    CFG_THROTTLE_TEMP  = 2'd2,
    CFG_MAX_FREQ_MHZ   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic       engine_enable;
    logic [7:0] emergency_temp;
    logic [7:0] throttle_temp;
    logic [7:0] max_freq_mhz;
  } cfg_t;

  typedef struct packed {
    logic        button_pressed;
    logic        host_awake;
    logic [31:0] heartbeat;
    logic [7:0]  temperature;
    logic [6:0]  cpu_load;
  } item_t;

  typedef struct packed {
    logic [7:0] target_freq_mhz;
    logic [2:0] boot_reason;
    logic       reset_request;
  } result_t;

endpackage

FILE: hw/rtl/sst_cfg_regs.sv
`timescale 1ns / 1ps

module sst_cfg_regs import sst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ENGINE_ENABLE:  cfg_d.engine_enable  = cfg_data_i[0];
        CFG_EMERGENCY_TEMP: cfg_d.emergency_temp = cfg_data_i;
        CFG_THROTTLE_TEMP:  cfg_d.throttle_temp  = cfg_data_i;
        CFG_MAX_FREQ_MHZ:   cfg_d.max_freq_mhz   = cfg_data_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.engine_enable  <= 1'b0;
      cfg_q.emergency_temp <= 8'd105;
      cfg_q.throttle_temp  <= 8'd85;
      cfg_q.max_freq_mhz   <= 8'd240;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/sst_engine.sv
`timescale 1ns / 1ps

module sst_engine import sst_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    step_i,
  input  item_t   item_i,
  output result_t result_o
);

  logic [13:0] press_q, press_d;
  logic [13:0] stale_q, stale_d;
  logic [31:0] last_hb_q, last_hb_d;
  logic [6:0]  sched_q, sched_d;
  logic [11:0] uptime_q, uptime_d;
  reason_e     reason_q, reason_d;
  logic [7:0]  freq_q, freq_d;

  logic [11:0] uptime_n;
  logic [13:0] press_n;
  logic [13:0] stale_n;
  logic [31:0] last_hb_n;
  logic [6:0]  sched_inc;
  logic        sched_hit;
  reason_e     reason_n;
  logic        forced;
  logic        wdt;
  logic        thermal;
  logic        req;
  logic [7:0]  target;
  logic [7:0]  target_cap;

  always_comb begin
    uptime_n = (uptime_q < 12'(UptimeSatMs)) ? uptime_q + 12'(TickMs) : uptime_q;

    // button hold timing and release decode
    reason_n = reason_q;
    forced   = 1'b0;
    press_n  = press_q;
    if (item_i.button_pressed) begin
      if (press_q < 14'(PressSatMs)) begin
        press_n = press_q + 14'(TickMs);
      end
      forced = item_i.host_awake && (press_n >= 14'(ForceMs));
    end else if (press_q != '0) begin
      if (!item_i.host_awake) begin
        if (press_q >= 14'(SetupMs)) begin
          reason_n = REASON_SETUP;
        end else if (press_q >= 14'(NormalMs)) begin
          reason_n = REASON_NORMAL;
        end
      end
      press_n = '0;
    end

    // heartbeat watchdog
    wdt       = 1'b0;
    last_hb_n = item_i.heartbeat;
    stale_n   = '0;
    if (item_i.host_awake && (item_i.heartbeat == last_hb_q)) begin
      last_hb_n = last_hb_q;
      stale_n   = stale_q + 14'(TickMs);
      wdt       = stale_n >= 14'(WdtMs);
    end

    // every tenth item: thermal check and frequency target
    sched_inc = sched_q + 7'(TickMs);
    sched_hit = sched_inc >= 7'(SchedMs);
    thermal   = sched_hit && (uptime_n > 12'(UptimeArmMs)) &&
                (item_i.temperature >= cfg_i.emergency_temp) && item_i.host_awake;

    if (item_i.temperature >= cfg_i.throttle_temp) begin
      target = FreqLow;
    end else if (item_i.cpu_load > 7'(LoadHigh)) begin
      target = FreqHigh;
    end else if (item_i.cpu_load > 7'(LoadMed)) begin
      target = FreqMed;
    end else begin
      target = FreqLow;
    end
    target_cap = (target > cfg_i.max_freq_mhz) ? cfg_i.max_freq_mhz : target;

    req = forced || wdt || thermal;

    press_d  = press_q;
    stale_d  = stale_q;
    last_hb_d = last_hb_q;
    sched_d  = sched_q;
    uptime_d = uptime_q;
    reason_d = reason_q;
    freq_d   = freq_q;
    if (step_i && cfg_i.engine_enable) begin
      if (req) begin
        press_d   = '0;
        stale_d   = '0;
        last_hb_d = '0;
        sched_d   = '0;
        uptime_d  = '0;
        if (forced) begin
          reason_d = REASON_FORCED;
        end else if (wdt) begin
          reason_d = REASON_WATCHDOG;
        end else begin
          reason_d = REASON_THERMAL;
        end
      end else begin
        press_d   = press_n;
        stale_d   = stale_n;
        last_hb_d = last_hb_n;
        sched_d   = sched_hit ? '0 : sched_inc;
        uptime_d  = uptime_n;
        reason_d  = reason_n;
        if (sched_hit) begin
          freq_d = target_cap;
        end
      end
    end

    result_o.target_freq_mhz = freq_d;
    result_o.boot_reason     = reason_d;
    result_o.reset_request   = cfg_i.engine_enable && req;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_q   <= '0;
      stale_q   <= '0;
      last_hb_q <= '0;
      sched_q   <= '0;
      uptime_q  <= '0;
      reason_q  <= REASON_NONE;
      freq_q    <= FreqLow;
    end else begin
      press_q   <= press_d;
      stale_q   <= stale_d;
      last_hb_q <= last_hb_d;
      sched_q   <= sched_d;
      uptime_q  <= uptime_d;
      reason_q  <= reason_d;
      freq_q    <= freq_d;
    end
  end

endmodule

FILE: hw/rtl/system_supervisor_tick.sv
`timescale 1ns / 1ps

// Supervisor for one 10 ms tick per item: times button holds, decodes boot
// reasons, watches the host heartbeat and every tenth item checks thermal
// shutdown and picks a frequency target. One item is accepted per clock cycle
// while the input is not stalled, and its result is registered: the item is
// registered, the whole update runs as combinational logic against the
// supervisor state, and the result lands in an output register. A stalled
// output holds up input only once both registers are full. Configuration must
// be written by the user only while no item is in flight; the block does not enforce it.
module system_supervisor_tick import sst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        button_pressed_i,
  input  logic        host_awake_i,
  input  logic [31:0] heartbeat_i,
  input  logic [7:0]  temperature_i,
  input  logic [6:0]  cpu_load_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  target_freq_mhz_o,
  output logic [2:0]  boot_reason_o,
  output logic        reset_request_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid_q;
  result_t res_d, res_q;
  logic    out_valid_q;
  logic    out_free;
  logic    step;
  logic    in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  sst_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sst_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (step),
    .item_i   (item_q),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.button_pressed <= button_pressed_i;
      item_q.host_awake     <= host_awake_i;
      item_q.heartbeat      <= heartbeat_i;
      item_q.temperature    <= temperature_i;
      item_q.cpu_load       <= cpu_load_i;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign target_freq_mhz_o = res_q.target_freq_mhz;
  assign boot_reason_o     = res_q.boot_reason;
  assign reset_request_o   = res_q.reset_request;

endmodule

FILE: hw/rtl/sst_checker.sv
`timescale 1ns / 1ps

module sst_checker import sst_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  target_freq_mhz_o,
  input logic [2:0]  boot_reason_o,
  input logic        reset_request_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(target_freq_mhz_o) &&
      $stable(boot_reason_o) && $stable(reset_request_o))
    else $error("stalled result changed");

  // input backs up only behind a full, stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // a reset request always carries a reset reason
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reset_request_o |->
      boot_reason_o == REASON_FORCED || boot_reason_o == REASON_WATCHDOG ||
      boot_reason_o == REASON_THERMAL)
    else $error("reset request with non-reset reason");

  // frequency target never exceeds the top step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> target_freq_mhz_o <= FreqHigh)
    else $error("frequency target out of range");

endmodule

bind system_supervisor_tick sst_checker u_sst_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .target_freq_mhz_o (target_freq_mhz_o),
  .boot_reason_o     (boot_reason_o),
  .reset_request_o   (reset_request_o)
);
